@@ design/ccr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccr_pkg
// Types and constant tables for the challenge-response digest/mix block.
// ----------------------------------------------------------------------------
package ccr_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MD_FETCH,
        ST_MD_ROUND,
        ST_MD_ADD,
        ST_MX_FETCH,
        ST_MX_OP,
        ST_EMIT
    } state_t;

    // modular mix operations run on the shared multiply/reduce unit
    typedef enum logic [2:0] {
        OP_U,
        OP_T,
        OP_V,
        OP_HI,
        OP_FH,
        OP_FL
    } op_t;

    localparam logic [127:0] KEY_TEXT  = "CFHUR$52U_{VIX5T";
    localparam logic [127:0] PROD_TEXT = "PROD0101{0RM?UBW";

    localparam logic [30:0] MIX_MOD = 31'h7FFF_FFFF;
    localparam logic [31:0] MIX_MUL = 32'h0E79_A9C1;

    localparam logic [31:0] IV0 = 32'h6745_2301;
    localparam logic [31:0] IV1 = 32'hefcd_ab89;
    localparam logic [31:0] IV2 = 32'h98ba_dcfe;
    localparam logic [31:0] IV3 = 32'h1032_5476;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [7:0] PAD_ZERO  = 8'h30;
    localparam logic [4:0] LAST_CHAR = 5'd31;
    localparam logic [2:0] LAST_STEP = 3'd5;

    // per-round additive constants
    function automatic logic [31:0] md_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    // rotate amounts, indexed by {round group, round[1:0]}
    function automatic logic [4:0] md_s(input logic [3:0] i);
        logic [4:0] s;
        begin
            case (i)
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

endpackage
`default_nettype wire

@@ design/chat_challenge_response_md5_mix.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chat_challenge_response_md5_mix
// Challenge-response generator: MD5 over challenge plus key, modular mix
// over challenge plus product ID, result sent as 32 lowercase hex chars.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle and stored up to MAX_CHALLENGE (extra bytes
// are dropped). The beat with tlast starts the response; s_tready stays low
// until all 32 characters have left. With n stored bytes and L = n + 16, the
// response first runs B = (L+8)/64 + 1 digest blocks (fetch, then rounds at
// one round per cycle, then add) and then P = L/8 + 1 mix pairs (a fetch and
// four passes each through the single multiply/reduce unit); then 32 beats out.
// ----------------------------------------------------------------------------
module chat_challenge_response_md5_mix #(
    parameter int MAX_CHALLENGE = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] challenge_byte
    input  wire logic       s_tlast,   // final_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [6:0] hex_char, [7] zero
    output logic            m_tlast    // final_char
);

    localparam int AW = $clog2(MAX_CHALLENGE);
    localparam int CW = $clog2(MAX_CHALLENGE + 1);
    localparam int LO_W = 40;

    ccr_pkg::state_t state_reg, state_next;
    ccr_pkg::op_t    op_reg;

    logic [7:0]    mem [MAX_CHALLENGE];
    logic [7:0]    mem_q_reg;
    logic [CW-1:0] cnt_reg, n_reg;
    logic [2:0]    blk_reg;
    logic [6:0]    k_reg;
    logic          fv_reg;
    logic [8:0]    pos_d_reg;
    logic [5:0]    rnd_reg;
    logic [5:0]    pair_reg;
    logic [2:0]    step_reg;
    logic [4:0]    chr_reg;
    logic [511:0]  buf_reg;
    logic [31:0]   a_reg, b_reg, c_reg, d_reg;
    logic [31:0]   h_reg [4];
    logic [63:0]   prod_reg, acc_reg;
    logic [30:0]   u_reg, t_reg, hi_reg, mixh_reg, mixl_reg;
    logic [LO_W-1:0] lo_reg;

    // message geometry
    logic [8:0] len, pad8, base, pos_iss, rel;
    logic [2:0] nblk;
    logic [5:0] npairs;
    logic [6:0] flen;
    logic       in_fetch, md_mode, rd_en;
    logic [7:0] byte_sel;

    assign len    = 9'(n_reg) + 9'd16;
    assign nblk   = 3'(len[8:6] + ((len[5:0] >= 6'd56) ? 3'd1 : 3'd0)) + 3'd1;
    assign pad8   = {nblk, 6'b0} - 9'd8;
    assign npairs = 6'(len[8:3]) + 6'd1;

    assign md_mode  = (state_reg == ccr_pkg::ST_MD_FETCH);
    assign in_fetch = md_mode || (state_reg == ccr_pkg::ST_MX_FETCH);
    assign base     = md_mode ? {blk_reg, 6'b0} : {pair_reg, 3'b0};
    assign flen     = md_mode ? 7'd64 : 7'd8;
    assign pos_iss  = base + 9'(k_reg);
    assign rd_en    = in_fetch && (k_reg < flen) && (pos_iss < 9'(n_reg));
    assign rel      = pos_d_reg - 9'(n_reg);

    // byte at the delayed fetch position
    always_comb
    begin
        if (pos_d_reg < 9'(n_reg))
            byte_sel = mem_q_reg;
        else if (pos_d_reg < len)
            byte_sel = md_mode ? ccr_pkg::KEY_TEXT[127 - 8*rel[3:0] -: 8]
                               : ccr_pkg::PROD_TEXT[127 - 8*rel[3:0] -: 8];
        else if (!md_mode)
            byte_sel = ccr_pkg::PAD_ZERO;
        else if (pos_d_reg == len)
            byte_sel = ccr_pkg::PAD_MARK;
        else if (pos_d_reg == pad8)
            byte_sel = {len[4:0], 3'b0};
        else if (pos_d_reg == pad8 + 9'd1)
            byte_sel = {4'b0, len[8:5]};
        else
            byte_sel = 8'h00;
    end

    // MD5 round logic
    logic [31:0] f, w_g, t_sum, rot;
    logic [3:0]  g, i4;
    logic [4:0]  s;
    logic [63:0] rot_w;

    assign i4 = rnd_reg[3:0];
    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = i4;
            end
            2'd1:
            begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = 4'(i4 * 4'd5 + 4'd1);
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(i4 * 4'd3 + 4'd5);
            end
            default:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(i4 * 4'd7);
            end
        endcase
    end
    assign s     = ccr_pkg::md_s({rnd_reg[5:4], rnd_reg[1:0]});
    assign w_g   = buf_reg[32*g +: 32];
    assign t_sum = a_reg + f + ccr_pkg::md_k(rnd_reg) + w_g;
    assign rot_w = {t_sum, t_sum} << s;
    assign rot   = rot_w[63:32];

    // shared multiply/reduce operand select
    logic [31:0] op_a, op_b;
    logic [63:0] op_c, fold;
    logic [30:0] res;

    always_comb
    begin
        case (op_reg)
            ccr_pkg::OP_U:
            begin
                op_a = ccr_pkg::MIX_MUL;
                op_b = buf_reg[479:448];
                op_c = 64'd0;
            end
            ccr_pkg::OP_T:
            begin
                op_a = {1'b0, h_reg[0][30:0]};
                op_b = {1'b0, u_reg} + {1'b0, hi_reg};
                op_c = 64'(h_reg[1][30:0]);
            end
            ccr_pkg::OP_V:
            begin
                op_a = 32'd1;
                op_b = buf_reg[511:480];
                op_c = 64'(t_reg);
            end
            ccr_pkg::OP_HI:
            begin
                op_a = {1'b0, h_reg[2][30:0]};
                op_b = {1'b0, u_reg};
                op_c = 64'(h_reg[3][30:0]);
            end
            ccr_pkg::OP_FH:
            begin
                op_a = 32'd1;
                op_b = {1'b0, hi_reg};
                op_c = 64'(h_reg[1][30:0]);
            end
            default:
            begin
                // low mix: running sum plus the fourth digest part
                op_a = 32'd1;
                op_b = {1'b0, h_reg[3][30:0]};
                op_c = 64'(lo_reg);
            end
        endcase
    end
    assign fold = 64'(acc_reg[30:0]) + (acc_reg >> 31);
    assign res  = (acc_reg >= 64'(ccr_pkg::MIX_MOD)) ? 31'd0 : acc_reg[30:0];

    // output character
    logic [31:0] ow;
    logic [7:0]  ob;
    logic [3:0]  nib;
    logic [6:0]  hex;

    assign ow  = h_reg[chr_reg[4:3]] ^ (chr_reg[3] ? {1'b0, mixl_reg} : {1'b0, mixh_reg});
    assign ob  = ow[8*chr_reg[2:1] +: 8];
    assign nib = chr_reg[0] ? ob[3:0] : ob[7:4];
    assign hex = (nib < 4'd10) ? (7'h30 + 7'(nib)) : (7'h57 + 7'(nib));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ccr_pkg::ST_IDLE:
                if (s_tvalid && s_tlast)
                    state_next = ccr_pkg::ST_MD_FETCH;
            ccr_pkg::ST_MD_FETCH:
                if (k_reg == flen)
                    state_next = ccr_pkg::ST_MD_ROUND;
            ccr_pkg::ST_MD_ROUND:
                if (rnd_reg == 6'd63)
                    state_next = ccr_pkg::ST_MD_ADD;
            ccr_pkg::ST_MD_ADD:
                state_next = (blk_reg == nblk - 3'd1) ? ccr_pkg::ST_MX_FETCH
                                                      : ccr_pkg::ST_MD_FETCH;
            ccr_pkg::ST_MX_FETCH:
                if (k_reg == flen)
                    state_next = ccr_pkg::ST_MX_OP;
            ccr_pkg::ST_MX_OP:
                if (step_reg == ccr_pkg::LAST_STEP)
                begin
                    if (op_reg == ccr_pkg::OP_FL)
                        state_next = ccr_pkg::ST_EMIT;
                    else if (op_reg == ccr_pkg::OP_HI && pair_reg != npairs - 6'd1)
                        state_next = ccr_pkg::ST_MX_FETCH;
                end
            ccr_pkg::ST_EMIT:
                if (m_tready && chr_reg == ccr_pkg::LAST_CHAR)
                    state_next = ccr_pkg::ST_IDLE;
            default:
                state_next = ccr_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        s_tready = (state_reg == ccr_pkg::ST_IDLE);
        m_tvalid = (state_reg == ccr_pkg::ST_EMIT);
        m_tdata  = {1'b0, hex};
        m_tlast  = (chr_reg == ccr_pkg::LAST_CHAR);
    end

    // challenge store and fetch read port
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready && cnt_reg < CW'(MAX_CHALLENGE))
            mem[cnt_reg[AW-1:0]] <= s_tdata;
        if (rd_en)
            mem_q_reg <= mem[pos_iss[AW-1:0]];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ccr_pkg::ST_IDLE;
            cnt_reg   <= '0;
            n_reg     <= '0;
            blk_reg   <= '0;
            k_reg     <= '0;
            fv_reg    <= 1'b0;
            rnd_reg   <= '0;
            pair_reg  <= '0;
            step_reg  <= '0;
            op_reg    <= ccr_pkg::OP_U;
            chr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fv_reg    <= in_fetch && (k_reg < flen);
            case (state_reg)
                ccr_pkg::ST_IDLE:
                    if (s_tvalid)
                    begin
                        if (s_tlast)
                        begin
                            n_reg   <= (cnt_reg < CW'(MAX_CHALLENGE)) ? cnt_reg + 1'b1
                                                                       : cnt_reg;
                            cnt_reg <= '0;
                            blk_reg <= '0;
                            k_reg   <= '0;
                        end
                        else if (cnt_reg < CW'(MAX_CHALLENGE))
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                ccr_pkg::ST_MD_FETCH, ccr_pkg::ST_MX_FETCH:
                begin
                    k_reg    <= (k_reg == flen) ? 7'd0 : k_reg + 7'd1;
                    rnd_reg  <= '0;
                    step_reg <= '0;
                    op_reg   <= ccr_pkg::OP_U;
                end
                ccr_pkg::ST_MD_ROUND:
                    rnd_reg <= rnd_reg + 6'd1;
                ccr_pkg::ST_MD_ADD:
                begin
                    blk_reg  <= blk_reg + 3'd1;
                    pair_reg <= '0;
                end
                ccr_pkg::ST_MX_OP:
                    if (step_reg == ccr_pkg::LAST_STEP)
                    begin
                        step_reg <= '0;
                        case (op_reg)
                            ccr_pkg::OP_U:  op_reg <= ccr_pkg::OP_T;
                            ccr_pkg::OP_T:  op_reg <= ccr_pkg::OP_V;
                            ccr_pkg::OP_V:  op_reg <= ccr_pkg::OP_HI;
                            ccr_pkg::OP_HI:
                                if (pair_reg == npairs - 6'd1)
                                    op_reg <= ccr_pkg::OP_FH;
                                else
                                    pair_reg <= pair_reg + 6'd1;
                            ccr_pkg::OP_FH: op_reg <= ccr_pkg::OP_FL;
                            default:        chr_reg <= '0;
                        endcase
                    end
                    else
                        step_reg <= step_reg + 3'd1;
                ccr_pkg::ST_EMIT:
                    if (m_tready)
                        chr_reg <= chr_reg + 5'd1;
                default:
                    ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pos_d_reg <= pos_iss;
        if (in_fetch && fv_reg)
            buf_reg <= {byte_sel, buf_reg[511:8]};
        case (state_reg)
            ccr_pkg::ST_IDLE:
            begin
                h_reg[0] <= ccr_pkg::IV0;
                h_reg[1] <= ccr_pkg::IV1;
                h_reg[2] <= ccr_pkg::IV2;
                h_reg[3] <= ccr_pkg::IV3;
                a_reg    <= ccr_pkg::IV0;
                b_reg    <= ccr_pkg::IV1;
                c_reg    <= ccr_pkg::IV2;
                d_reg    <= ccr_pkg::IV3;
            end
            ccr_pkg::ST_MD_ROUND:
            begin
                a_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= b_reg;
                b_reg <= b_reg + rot;
            end
            ccr_pkg::ST_MD_ADD:
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                a_reg    <= h_reg[0] + a_reg;
                b_reg    <= h_reg[1] + b_reg;
                c_reg    <= h_reg[2] + c_reg;
                d_reg    <= h_reg[3] + d_reg;
                hi_reg   <= '0;
                lo_reg   <= '0;
            end
            ccr_pkg::ST_MX_OP:
            begin
                // multiply, add, three folds, then final reduce and write back
                case (step_reg)
                    3'd0:    prod_reg <= op_a * op_b;
                    3'd1:    acc_reg  <= prod_reg + op_c;
                    3'd2, 3'd3, 3'd4:
                             acc_reg  <= fold;
                    default:
                        case (op_reg)
                            ccr_pkg::OP_U, ccr_pkg::OP_V: u_reg <= res;
                            ccr_pkg::OP_T:  t_reg <= res;
                            ccr_pkg::OP_HI:
                            begin
                                hi_reg <= res;
                                lo_reg <= lo_reg + LO_W'(res) + LO_W'(t_reg);
                            end
                            ccr_pkg::OP_FH: mixh_reg <= res;
                            default:        mixl_reg <= res;
                        endcase
                endcase
            end
            default:
                ;
        endcase
    end

`ifndef ASSERT_OFF
    // input and output sides are never open together
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output both active");

    // the last character returns the block to taking bytes
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("block not idle after last character");

    // a character taken before the last is followed by another one
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("response cut short");

    // a final beat always starts the computation
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("final beat did not start response");
`endif

endmodule
`default_nettype wire
